FILE: src/mstw_pkg.sv
`timescale 1ns / 1ps

package mstw_pkg;

  // Width of the tree weight result and its saturation limit
  localparam int unsigned TOTAL_BITS = 20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // Width and reset value of the vertex count register
  localparam int unsigned NODE_COUNT_BITS = 5;
  localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 5'd6;

  // Width of the vertex index fields of an entry word
  localparam int unsigned VERTEX_FIELD_BITS = 4;

  // Width of the weight field of an entry word
  localparam int unsigned WEIGHT_FIELD_BITS = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_DONE
  } mstw_state_e;

endpackage

FILE: src/mstw_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read memory with registered read data.
module mstw_ram #(
  parameter int unsigned WIDTH     = 17,
  parameter int unsigned ADDR_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/minimum_spanning_tree_weight.sv
`timescale 1ns / 1ps

// Minimum spanning tree weight of an undirected graph (Prim's algorithm).
// Input channel (in_valid_i / in_ready_o): one adjacency-matrix entry per word,
// row, column, weight, present flag and a last flag. Entries are stored in a
// matrix memory, one word per cycle; entries outside the capacity are dropped.
// A word with last_entry_i set is stored, then a run over the first node_count
// vertices starts from vertex 0. No input word is taken during a run.
// Output channel (out_valid_o / out_ready_i): one word per run, the tree weight
// and a connected flag; the weight reads zero when the graph is disconnected.
// Steps after the last entry: a seed pass over the distance memory, then for
// each vertex added a scan, a pick and a relax pass, plus a final scan, a
// pick and an output step; a split graph ends sooner. Each pass is bound by
// the single read port of the matrix and distance memories, one vertex per cycle.
// A finished result waits in the output register while out_ready_i is low; the
// next input word is taken in the cycle that result is taken, or later.
// Reset: node_count returns to 6, control state clears; matrix and distance
// memories keep undefined contents until written.
module minimum_spanning_tree_weight
  import mstw_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [NODE_COUNT_BITS-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [VERTEX_FIELD_BITS-1:0] row_vertex_i,
  input  logic [VERTEX_FIELD_BITS-1:0] col_vertex_i,
  input  logic [WEIGHT_FIELD_BITS-1:0] edge_weight_i,
  input  logic                         edge_present_i,
  input  logic                         last_entry_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [TOTAL_BITS-1:0]        tree_weight_o,
  output logic                         connected_o
);

  localparam int unsigned VB = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = WEIGHT_BITS + 1;
  localparam int unsigned SW = (WEIGHT_BITS + 2 > TOTAL_BITS + 1) ?
                               WEIGHT_BITS + 2 : TOTAL_BITS + 1;
  localparam logic [DW-1:0] DIST_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  mstw_state_e state_q, state_d;

  logic [NODE_COUNT_BITS-1:0] nc_q;
  logic [NW-1:0]              n_q, n_d, n_eff;
  logic [NW-1:0]              cnt_q, cnt_d;
  logic                       pend_q, pend_d;
  logic [VB-1:0]              pidx_q, pidx_d;
  logic [VB-1:0]              pick_q, pick_d;
  logic [DW-1:0]              best_q, best_d;
  logic                       found_q, found_d;
  logic [MAX_VERTICES-1:0]    visited_q, visited_d;
  logic [NW-1:0]              reached_q, reached_d;
  logic [TOTAL_BITS-1:0]      total_q, total_d;
  logic                       out_valid_q, out_valid_d;
  logic [TOTAL_BITS-1:0]      tree_weight_q, tree_weight_d;
  logic                       connected_q, connected_d;

  logic                       issue;
  logic                       in_range;
  logic [SW-1:0]              sum;
  logic [DW-1:0]              link_dist;

  logic                       mat_we;
  logic [2*VB-1:0]            mat_waddr, mat_raddr;
  logic [DW-1:0]              mat_wdata, mat_rdata;
  logic                       dist_we;
  logic [VB-1:0]              dist_waddr;
  logic [DW-1:0]              dist_wdata, dist_rdata;

  // Matrix store: present flag above the weight, row-major address
  mstw_ram #(
    .WIDTH     (DW),
    .ADDR_BITS (2 * VB)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  // Tentative distance per vertex
  mstw_ram #(
    .WIDTH     (DW),
    .ADDR_BITS (VB)
  ) u_dist (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (cnt_q[VB-1:0]),
    .rdata_o (dist_rdata)
  );

  // Vertex count in use: zero counts as one, larger values clip to capacity
  always_comb begin
    if (nc_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(nc_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(nc_q);
    end
  end

  assign in_range  = (32'(row_vertex_i) < MAX_VERTICES) && (32'(col_vertex_i) < MAX_VERTICES);
  assign mat_waddr = {VB'(row_vertex_i), VB'(col_vertex_i)};
  assign mat_wdata = {edge_present_i, WEIGHT_BITS'(edge_weight_i)};
  // Seed pass reads column 0 of each row; relax pass reads the picked row
  assign mat_raddr = (state_q == ST_RELAX) ? {pick_q, cnt_q[VB-1:0]}
                                           : {cnt_q[VB-1:0], VB'(0)};
  // A missing edge reads as infinite distance
  assign link_dist = mat_rdata[WEIGHT_BITS] ? {1'b0, mat_rdata[WEIGHT_BITS-1:0]} : DIST_INF;
  assign issue     = cnt_q < n_q;
  assign sum       = SW'(total_q) + SW'(best_q);

  assign in_ready_o    = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign tree_weight_o = tree_weight_q;
  assign connected_o   = connected_q;

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    cnt_d         = cnt_q;
    pend_d        = 1'b0;
    pidx_d        = cnt_q[VB-1:0];
    pick_d        = pick_q;
    best_d        = best_q;
    found_d       = found_q;
    visited_d     = visited_q;
    reached_d     = reached_q;
    total_d       = total_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    tree_weight_d = tree_weight_q;
    connected_d   = connected_q;
    mat_we        = 1'b0;
    dist_we       = 1'b0;
    dist_waddr    = pidx_q;
    dist_wdata    = link_dist;

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_ready_o) begin
          mat_we = in_range;
          if (last_entry_i) begin
            state_d   = ST_INIT;
            n_d       = n_eff;
            cnt_d     = '0;
            visited_d = MAX_VERTICES'(1);
            reached_d = NW'(1);
            total_d   = '0;
          end
        end
      end
      ST_INIT: begin
        if (issue) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + NW'(1);
        end
        if (pend_q) begin
          dist_we = 1'b1;
          // Root vertex starts at distance zero
          if (pidx_q == '0) begin
            dist_wdata = '0;
          end
        end
        if (!issue && !pend_q) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          best_d  = DIST_INF;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + NW'(1);
        end
        // Strict compare keeps the lowest vertex on a tie
        if (pend_q && !visited_q[pidx_q] && (dist_rdata < best_q)) begin
          best_d  = dist_rdata;
          pick_d  = pidx_q;
          found_d = 1'b1;
        end
        if (!issue && !pend_q) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!found_q) begin
          state_d = ST_DONE;
        end else begin
          visited_d[pick_q] = 1'b1;
          reached_d         = reached_q + NW'(1);
          total_d           = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
          cnt_d             = '0;
          state_d           = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (issue) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + NW'(1);
        end
        if (pend_q && !visited_q[pidx_q] && (dist_rdata > link_dist)) begin
          dist_we = 1'b1;
        end
        if (!issue && !pend_q) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          best_d  = DIST_INF;
          found_d = 1'b0;
        end
      end
      ST_DONE: begin
        out_valid_d   = 1'b1;
        connected_d   = reached_q >= n_q;
        tree_weight_d = (reached_q >= n_q) ? total_q : '0;
        state_d       = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      nc_q        <= NODE_COUNT_RESET;
      n_q         <= NW'(1);
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      visited_q   <= '0;
      reached_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        nc_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      visited_q   <= visited_d;
      reached_q   <= reached_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    pidx_q        <= pidx_d;
    pick_q        <= pick_d;
    best_q        <= best_d;
    tree_weight_q <= tree_weight_d;
    connected_q   <= connected_d;
  end

  a_disc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !connected_o |-> tree_weight_o == '0)
    else $error("disconnected result carries a nonzero weight");

  a_reach_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_LOAD |-> reached_q <= n_q)
    else $error("more vertices reached than in use");

  a_root_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_PICK || state_q == ST_RELAX) |-> visited_q[0])
    else $error("root vertex not marked visited");

  a_relax_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RELAX && pend_q && issue |-> pidx_q != cnt_q[VB-1:0])
    else $error("distance write and read hit the same vertex");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_o)
    else $error("finished run did not present a result");

endmodule

FILE: tb/tb_minimum_spanning_tree_weight.sv
`timescale 1ns / 1ps

// Spanning-tree weight check. Stream adjacency-matrix words into the block,
// mirror every accepted word into a local copy of the matrix, and on each
// last-flagged word run Prim over the local copy to get the tree weight and
// connected flag. Compare each result word with the oldest prediction.
module tb_minimum_spanning_tree_weight;
  import mstw_pkg::*;

  localparam int unsigned VERTS         = 16;
  // Settle time after the last word, sized for a run over all 16 vertices
  localparam int unsigned SETTLE_CYCLES = 2 * VERTS * VERTS + 5 * VERTS + 16;
  localparam int unsigned ENTRY_TARGET  = 1100;
  localparam int unsigned TREE_TARGET   = 60;
  localparam int unsigned IDLE_PCT      = 26;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned HOLD_AT_TREE  = 30;
  localparam int unsigned PAUSE_AT      = 650;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_BUDGET  = 80;
  localparam int unsigned DIRECTED_ROWS = 22;
  localparam int unsigned LISTED_PHASES = 9;
  // Distance of a missing edge: one above the widest weight
  localparam logic [WEIGHT_FIELD_BITS:0] NO_LINK = {1'b1, {WEIGHT_FIELD_BITS{1'b0}}};

  typedef enum logic {ROW_ENTRY, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {WM_FULL, WM_TIES, WM_EXTREME} weight_mode_e;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] weight;
    logic                  conn;
  } tree_t;

  // One row of the directed part: either a vertex-count write or an entry
  // word, with the result typed in where it is obvious.
  typedef struct packed {
    row_kind_e                      kind;
    logic [NODE_COUNT_BITS-1:0]     count;
    logic [VERTEX_FIELD_BITS-1:0]   row;
    logic [VERTEX_FIELD_BITS-1:0]   col;
    logic [WEIGHT_FIELD_BITS-1:0]   weight;
    logic                           present;
    logic                           last;
    logic                           typed;
    logic [TOTAL_BITS-1:0]          want_weight;
    logic                           want_conn;
  } step_t;

  logic                         clk_i;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [NODE_COUNT_BITS-1:0]   cfg_wdata_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [VERTEX_FIELD_BITS-1:0] row_vertex_i   = '0;
  logic [VERTEX_FIELD_BITS-1:0] col_vertex_i   = '0;
  logic [WEIGHT_FIELD_BITS-1:0] edge_weight_i  = '0;
  logic                         edge_present_i = 1'b0;
  logic                         last_entry_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [TOTAL_BITS-1:0]        tree_weight_o;
  logic                         connected_o;

  // Local copy of the matrix and the vertex count, updated on acceptance
  logic [WEIGHT_FIELD_BITS-1:0] graph_weight [VERTS*VERTS];
  logic                         graph_linked [VERTS*VERTS];
  logic [NODE_COUNT_BITS-1:0]   node_count_now = NODE_COUNT_RESET;

  tree_t       pending_trees [$];
  int unsigned cycle_no       = 0;
  int unsigned entries_sent   = 0;
  int unsigned trees_queued   = 0;
  int unsigned trees_checked  = 0;
  int unsigned trees_spanning = 0;
  int unsigned bad_trees      = 0;
  int unsigned count_writes   = 0;
  bit          ended_on_last  = 1'b0;

  localparam logic [NODE_COUNT_BITS-1:0] PHASE_COUNTS [LISTED_PHASES] =
    '{5'd31, 5'd17, 5'd0, 5'd1, 5'd2, 5'd16, 5'd4, 5'd9, 5'd3};

  // Directed rows: single vertex, zero count, widest weight, missing edge,
  // zero-weight edge, a tie between two nearest vertices and a lopsided
  // matrix. Only cells inside the active square are ever read.
  step_t directed_steps [DIRECTED_ROWS] = '{
    '{ROW_CONFIG, 5'd1, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd0, 16'h1234, 1'b1, 1'b1, 1'b1, 20'd0,     1'b1},
    '{ROW_CONFIG, 5'd0, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b1, 1'b1, 20'd0,     1'b1},
    '{ROW_CONFIG, 5'd2, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd1, 16'h0000, 1'b0, 1'b1, 1'b1, 20'd65535, 1'b1},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd1, 16'h0000, 1'b0, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd0, 16'h0000, 1'b0, 1'b1, 1'b1, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd1, 16'h0000, 1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b1, 20'd0,     1'b1},
    '{ROW_CONFIG, 5'd3, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd2, 4'd0, 16'd5,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd2, 16'd5,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd2, 4'd1, 16'd5,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd2, 16'd5,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd2, 4'd2, 16'd9,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd1, 16'd5,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd0, 16'd5,    1'b1, 1'b1, 1'b1, 20'd10,    1'b1},
    '{ROW_ENTRY,  5'd0, 4'd1, 4'd0, 16'd7,    1'b1, 1'b0, 1'b0, 20'd0,     1'b0},
    '{ROW_ENTRY,  5'd0, 4'd0, 4'd1, 16'd3,    1'b1, 1'b1, 1'b0, 20'd0,     1'b0}
  };

  minimum_spanning_tree_weight #(
    .MAX_VERTICES(VERTS),
    .WEIGHT_BITS (16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .row_vertex_i  (row_vertex_i),
    .col_vertex_i  (col_vertex_i),
    .edge_weight_i (edge_weight_i),
    .edge_present_i(edge_present_i),
    .last_entry_i  (last_entry_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tree_weight_o (tree_weight_o),
    .connected_o   (connected_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  // Idle odds for both sides; every fourth window of the cycle counter runs flat out
  function automatic int unsigned gap_chance();
    return ((cycle_no / 2500) % 4 == 3) ? 0 : IDLE_PCT;
  endfunction

  // Clamp the vertex count: zero acts as one, anything past capacity saturates
  function automatic int unsigned vertices_in_use(input logic [NODE_COUNT_BITS-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > VERTS) return VERTS;
    return 32'(cnt);
  endfunction

  function automatic logic [WEIGHT_FIELD_BITS:0] link_length(input int unsigned r,
                                                              input int unsigned c);
    int unsigned k;
    k = r * VERTS + c;
    return graph_linked[k] ? {1'b0, graph_weight[k]} : NO_LINK;
  endfunction

  // Prim from vertex 0 over the local matrix. Seed from column 0, relax along
  // the row of the vertex just added, break ties toward the lower index.
  function automatic tree_t compute_tree(input logic [NODE_COUNT_BITS-1:0] cnt);
    int unsigned              n;
    int unsigned              reached;
    int unsigned              pick;
    logic [WEIGHT_FIELD_BITS:0] tent_dist [VERTS];
    bit                       seen [VERTS];
    logic [WEIGHT_FIELD_BITS:0] best;
    logic [TOTAL_BITS:0]      acc;
    bit                       found;
    tree_t                    res;
    n = vertices_in_use(cnt);
    for (int j = 0; j < n; j++) begin
      tent_dist[j] = link_length(j, 0);
      seen[j] = 1'b0;
    end
    tent_dist[0] = '0;
    seen[0] = 1'b1;
    acc = '0;
    reached = 1;
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      best = NO_LINK;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && tent_dist[j] < best) begin
          best = tent_dist[j];
          pick = j;
          found = 1'b1;
        end
      end
      if (found) begin
        seen[pick] = 1'b1;
        reached++;
        acc = acc + best;
        if (acc > {1'b0, TOTAL_MAX}) acc = {1'b0, TOTAL_MAX};
        for (int j = 0; j < n; j++) begin
          if (!seen[j] && tent_dist[j] > link_length(pick, j))
            tent_dist[j] = link_length(pick, j);
        end
      end
    end
    res.conn = (reached >= n);
    res.weight = res.conn ? acc[TOTAL_BITS-1:0] : '0;
    return res;
  endfunction

  function automatic logic [WEIGHT_FIELD_BITS-1:0] pick_weight(input weight_mode_e mode);
    case (mode)
      WM_TIES:    return WEIGHT_FIELD_BITS'($urandom_range(0, 3));
      WM_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:    return WEIGHT_FIELD_BITS'($urandom());
    endcase
  endfunction

  // Offer one entry word after a random gap, hold it until taken, then
  // mirror it into the local matrix and queue a prediction on a last word.
  task automatic send_entry(input logic [VERTEX_FIELD_BITS-1:0] row,
                            input logic [VERTEX_FIELD_BITS-1:0] col,
                            input logic [WEIGHT_FIELD_BITS-1:0] weight,
                            input logic present,
                            input logic last);
    while ($urandom_range(0, 99) < gap_chance()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    row_vertex_i   <= row;
    col_vertex_i   <= col;
    edge_weight_i  <= weight;
    edge_present_i <= present;
    last_entry_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    graph_weight[row * VERTS + col] = weight;
    graph_linked[row * VERTS + col] = present;
    entries_sent++;
    ended_on_last = last;
    if (last) begin
      pending_trees.push_back(compute_tree(node_count_now));
      trees_queued++;
    end
  endtask

  // Drop valid and hold until every queued result has been taken
  task automatic pause_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_trees.size() != 0);
  endtask

  // Write the vertex count only with the block idle and fully settled
  task automatic write_node_count(input logic [NODE_COUNT_BITS-1:0] value);
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_count_now = value;
    count_writes++;
  endtask

  // Rewrite a symmetric square block inside the active vertices, row-major,
  // and flag the last word. A broken block stops at a random point with no last flag.
  task automatic rewrite_block(input int unsigned n, input bit broken, input bit whole);
    int unsigned                  m;
    int unsigned                  base;
    int unsigned                  cut;
    int unsigned                  sent;
    int unsigned                  pp;
    weight_mode_e                 mode;
    logic [WEIGHT_FIELD_BITS-1:0] w [VERTS][VERTS];
    bit                           p [VERTS][VERTS];
    if (whole) m = n;
    else m = ($urandom_range(0, 9) == 0) ? n : $urandom_range(1, (n < 6) ? n : 6);
    base = $urandom_range(0, n - m);
    mode = weight_mode_e'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       pp = 20;
      1:       pp = 60;
      2:       pp = 90;
      default: pp = 100;
    endcase
    if (whole) pp = 90;
    for (int i = 0; i < m; i++) begin
      for (int j = i; j < m; j++) begin
        w[i][j] = pick_weight(mode);
        p[i][j] = ($urandom_range(0, 99) < pp);
        w[j][i] = w[i][j];
        p[j][i] = p[i][j];
      end
    end
    cut = broken ? $urandom_range(1, m * m) : m * m;
    sent = 0;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < m; j++) begin
        if (sent < cut) begin
          send_entry(VERTEX_FIELD_BITS'(base + i), VERTEX_FIELD_BITS'(base + j),
                     w[i][j], p[i][j], !broken && (sent == cut - 1));
          sent++;
        end
      end
    end
  endtask

  // Update a few random edges in both directions, flag the last word
  task automatic patch_links(input int unsigned k);
    logic [VERTEX_FIELD_BITS-1:0] r;
    logic [VERTEX_FIELD_BITS-1:0] c;
    logic [WEIGHT_FIELD_BITS-1:0] wv;
    logic                         pv;
    for (int t = 0; t < k; t++) begin
      r  = VERTEX_FIELD_BITS'($urandom_range(0, 15));
      c  = VERTEX_FIELD_BITS'($urandom_range(0, 15));
      wv = pick_weight(weight_mode_e'($urandom_range(0, 2)));
      pv = 1'($urandom_range(0, 1));
      send_entry(r, c, wv, pv, 1'b0);
      send_entry(c, r, wv, pv, t == k - 1);
    end
  endtask

  // Result side: check each taken word against the oldest prediction, stall
  // at random, and once hold ready low for a long stretch so the block backs up.
  initial begin
    tree_t       want;
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_trees.size() == 0) begin
          bad_trees++;
          if (bad_trees <= REPORT_LIMIT)
            $display("unexpected result word: weight %0d connected %0b",
                     tree_weight_o, connected_o);
        end else begin
          want = pending_trees.pop_front();
          trees_checked++;
          if (want.conn) trees_spanning++;
          if (tree_weight_o !== want.weight || connected_o !== want.conn) begin
            bad_trees++;
            if (bad_trees <= REPORT_LIMIT)
              $display("result %0d: weight %0d connected %0b, expected %0d / %0b",
                       trees_checked, tree_weight_o, connected_o,
                       want.weight, want.conn);
          end
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!hold_done && trees_checked == HOLD_AT_TREE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= gap_chance());
      end
    end
  end

  // Stimulus: directed rows, a full matrix load, then phases at different
  // vertex counts with random blocks, patches, broken blocks and noise.
  initial begin
    step_t                      st;
    int unsigned                phase_no;
    int unsigned                n;
    int unsigned                budget;
    int unsigned                roll;
    logic [NODE_COUNT_BITS-1:0] cnt;
    bit                         paused;
    phase_no = 0;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      st = directed_steps[i];
      if (st.kind == ROW_CONFIG) begin
        write_node_count(st.count);
      end else begin
        send_entry(st.row, st.col, st.weight, st.present, st.last);
        // Typed-in value replaces the computed one for obvious rows
        if (st.last && st.typed)
          pending_trees[pending_trees.size() - 1] = '{st.want_weight, st.want_conn};
      end
    end

    // Load the whole matrix once so no later run can touch an unwritten cell
    write_node_count(5'd16);
    rewrite_block(VERTS, 1'b0, 1'b1);

    while (entries_sent < ENTRY_TARGET || trees_queued < TREE_TARGET) begin
      cnt = (phase_no < LISTED_PHASES) ? PHASE_COUNTS[phase_no]
                                       : NODE_COUNT_BITS'($urandom_range(0, 31));
      write_node_count(cnt);
      n = vertices_in_use(cnt);
      budget = entries_sent + PHASE_BUDGET;
      while (entries_sent < budget) begin
        if (!paused && entries_sent >= PAUSE_AT) begin
          pause_for_results();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          rewrite_block(n, 1'b0, 1'b0);
        end else if (roll < 75) begin
          patch_links($urandom_range(1, 4));
        end else if (roll < 88) begin
          rewrite_block(n, 1'b1, 1'b0);
        end else begin
          repeat ($urandom_range(1, 3))
            send_entry(VERTEX_FIELD_BITS'($urandom_range(0, 15)),
                       VERTEX_FIELD_BITS'($urandom_range(0, 15)),
                       WEIGHT_FIELD_BITS'($urandom()),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      // Close the phase with a run so the count can change safely
      if (!ended_on_last) patch_links(1);
      phase_no++;
    end

    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d entry words over %0d vertex-count settings", entries_sent, count_writes);
    $display("checked %0d trees: %0d spanning, %0d split",
             trees_checked, trees_spanning, trees_checked - trees_spanning);
    if (bad_trees == 0 && pending_trees.size() == 0) begin
      $display("minimum_spanning_tree_weight: match");
    end else begin
      $display("minimum_spanning_tree_weight: mismatch");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("minimum_spanning_tree_weight: mismatch");
    $finish;
  end

endmodule

FILE: minimum_spanning_tree_weight.f
src/mstw_pkg.sv
src/mstw_ram.sv
src/minimum_spanning_tree_weight.sv
tb/tb_minimum_spanning_tree_weight.sv
